/* hw/rtl/fmcrw_pkg.sv */
`default_nettype none

package fmcrw_pkg;

	localparam logic [2:0] CMD_OP_LEVEL = 3'd0;
	localparam logic [2:0] CMD_CONNECT  = 3'd1;
	localparam logic [2:0] CMD_VOLUME   = 3'd2;
	localparam logic [2:0] CMD_TONE     = 3'd3;
	localparam logic [2:0] CMD_KEY_ON   = 3'd4;
	localparam logic [2:0] CMD_KEY_OFF  = 3'd5;
	localparam logic [2:0] CMD_PAN      = 3'd6;

	localparam logic [7:0] ADDR_KEY    = 8'h08;
	localparam logic [7:0] ADDR_PAN    = 8'h20;
	localparam logic [7:0] ADDR_KEY_CD = 8'h28;
	localparam logic [7:0] ADDR_KEY_FR = 8'h30;
	localparam logic [7:0] ADDR_LEVEL  = 8'h60;

	localparam logic [7:0] LEVEL_MAX = 8'h7f;

	localparam int KEY_TABLE_DEPTH = 96;
	localparam int KEY_IDX_W       = $clog2(KEY_TABLE_DEPTH);

	localparam logic [7:0] VOL_TABLE [16] = '{
		8'h2a, 8'h28, 8'h25, 8'h22, 8'h20, 8'h1d, 8'h1a, 8'h18,
		8'h15, 8'h12, 8'h10, 8'h0d, 8'h0a, 8'h08, 8'h05, 8'h02
	};

	localparam logic [3:0] CARRIER_TABLE [8] = '{
		4'h8, 4'h8, 4'h8, 4'h8, 4'hc, 4'he, 4'he, 4'hf
	};

	localparam logic [7:0] KEYCODE_TABLE [KEY_TABLE_DEPTH] = '{
		8'h00, 8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h08, 8'h09, 8'h0a, 8'h0c, 8'h0d, 8'h0e,
		8'h10, 8'h11, 8'h12, 8'h14, 8'h15, 8'h16, 8'h18, 8'h19, 8'h1a, 8'h1c, 8'h1d, 8'h1e,
		8'h20, 8'h21, 8'h22, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2a, 8'h2c, 8'h2d, 8'h2e,
		8'h30, 8'h31, 8'h32, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h3a, 8'h3c, 8'h3d, 8'h3e,
		8'h40, 8'h41, 8'h42, 8'h44, 8'h45, 8'h46, 8'h48, 8'h49, 8'h4a, 8'h4c, 8'h4d, 8'h4e,
		8'h50, 8'h51, 8'h52, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5a, 8'h5c, 8'h5d, 8'h5e,
		8'h60, 8'h61, 8'h62, 8'h64, 8'h65, 8'h66, 8'h68, 8'h69, 8'h6a, 8'h6c, 8'h6d, 8'h6e,
		8'h70, 8'h71, 8'h72, 8'h74, 8'h75, 8'h76, 8'h78, 8'h79, 8'h7a, 8'h7c, 8'h7d, 8'h7e
	};

	typedef struct packed {
		logic [2:0]         cmd;
		logic [2:0]         channel;
		logic [1:0]         op_index;
		logic [7:0]         arg;
		logic [7:0]         key_slots;
		logic [15:0]        volume_offset;
		logic signed [15:0] fine_tune;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] reg_addr;
		logic [7:0] wr_data;
		logic       last;
	} wr_item_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] channel;
		logic [1:0] op_index;
		logic [7:0] arg;
		logic [7:0] key_slots;
		logic [8:0] atten;
		logic [5:0] tune_frac;
		logic [7:0] keycode;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

/* hw/rtl/fmcrw_front.sv */
`default_nettype none

module fmcrw_front #(
	parameter int CHANNELS = 8
) (
	input  wire                   cmd_valid,
	input  fmcrw_pkg::cmd_item_t  cmd_item,
	input  fmcrw_pkg::qstat_t     qstat,
	output logic                  cmd_stall,
	output logic                  push,
	output fmcrw_pkg::entry_t     entry
);

	logic              keep;
	logic [3:0]        vol_idx;
	logic [7:0]        vol;
	logic signed [9:0] semis;
	logic signed [10:0] note;
	logic [fmcrw_pkg::KEY_IDX_W-1:0] key_idx;

	assign keep = (32'(cmd_item.channel) < CHANNELS) && (cmd_item.cmd <= fmcrw_pkg::CMD_PAN);
	assign cmd_stall = qstat.full;
	assign push = cmd_valid && !qstat.full && keep;

	assign vol_idx = (cmd_item.arg[6:4] != 3'd0) ? 4'hf : cmd_item.arg[3:0];
	assign vol = cmd_item.arg[7] ? {1'b0, cmd_item.arg[6:0]} : fmcrw_pkg::VOL_TABLE[vol_idx];

	assign semis = cmd_item.fine_tune[15:6];
	assign note = $signed({3'b000, cmd_item.arg}) + $signed({semis[9], semis});

	always_comb begin
		if (note < 0) begin
			key_idx = '0;
		end else if (note > (fmcrw_pkg::KEY_TABLE_DEPTH - 1)) begin
			key_idx = fmcrw_pkg::KEY_IDX_W'(fmcrw_pkg::KEY_TABLE_DEPTH - 1);
		end else begin
			key_idx = note[fmcrw_pkg::KEY_IDX_W-1:0];
		end
	end

	always_comb begin
		entry.cmd       = cmd_item.cmd;
		entry.channel   = cmd_item.channel;
		entry.op_index  = cmd_item.op_index;
		entry.arg       = cmd_item.arg;
		entry.key_slots = cmd_item.key_slots;
		entry.atten     = {1'b0, vol} + {1'b0, cmd_item.volume_offset[15:8]};
		entry.tune_frac = cmd_item.fine_tune[5:0];
		entry.keycode   = fmcrw_pkg::KEYCODE_TABLE[key_idx];
	end

endmodule

`default_nettype wire

/* hw/rtl/fmcrw_queue.sv */
`default_nettype none

module fmcrw_queue #(
	parameter int DEPTH = 2
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  fmcrw_pkg::entry_t  push_entry,
	input  wire                pop,
	output fmcrw_pkg::entry_t  head,
	output fmcrw_pkg::qstat_t  qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fmcrw_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign head = mem_q[rd_ptr_q];
	assign qstat.full = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!qstat.full || pop)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count out of step");

endmodule

`default_nettype wire

/* hw/rtl/fmcrw_back.sv */
`default_nettype none

module fmcrw_back #(
	parameter int CHANNELS = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  fmcrw_pkg::entry_t   head,
	input  fmcrw_pkg::qstat_t   qstat,
	output logic                pop,
	input  wire                 wr_stall,
	output logic                wr_valid,
	output fmcrw_pkg::wr_item_t wr_item
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	logic [1:0]        step_q;
	fmcrw_pkg::entry_t cur_q;
	logic              out_valid_q;
	fmcrw_pkg::wr_item_t out_q;

	logic [7:0] op_level_q [CHANNELS*4];
	logic [7:0] fb_conn_q  [CHANNELS];
	logic [3:0] carrier_q  [CHANNELS];
	logic [7:0] slots_q    [CHANNELS];

	logic [CH_W-1:0]     ch;
	logic [7:0]          level;
	logic [9:0]          level_sum;
	logic                emits;
	logic                slot_free;
	logic                load;
	fmcrw_pkg::wr_item_t wr_next;

	assign ch = cur_q.channel[CH_W-1:0];
	assign level = op_level_q[{ch, step_q}];
	assign level_sum = {2'b00, level} + (carrier_q[ch][step_q] ? {1'b0, cur_q.atten} : 10'd0);
	assign slot_free = !out_valid_q || !wr_stall;
	assign pop = (state_q == ST_IDLE) && !qstat.empty;
	assign load = (state_q == ST_RUN) && emits && slot_free;

	always_comb begin
		emits = 1'b1;
		wr_next.reg_addr = fmcrw_pkg::ADDR_KEY;
		wr_next.wr_data = {5'b00000, cur_q.channel};
		wr_next.last = 1'b1;
		unique case (cur_q.cmd)
			fmcrw_pkg::CMD_VOLUME: begin
				wr_next.reg_addr = fmcrw_pkg::ADDR_LEVEL + {3'b000, step_q, 3'b000}
					+ {5'b00000, cur_q.channel};
				wr_next.wr_data = (level_sum > 10'(fmcrw_pkg::LEVEL_MAX))
					? fmcrw_pkg::LEVEL_MAX : level_sum[7:0];
				wr_next.last = (step_q == 2'd3);
			end
			fmcrw_pkg::CMD_TONE: begin
				if (step_q == 2'd0) begin
					wr_next.reg_addr = fmcrw_pkg::ADDR_KEY_FR + {5'b00000, cur_q.channel};
					wr_next.wr_data = {cur_q.tune_frac, 2'b00};
					wr_next.last = 1'b0;
				end else begin
					wr_next.reg_addr = fmcrw_pkg::ADDR_KEY_CD + {5'b00000, cur_q.channel};
					wr_next.wr_data = cur_q.keycode;
				end
			end
			fmcrw_pkg::CMD_KEY_ON: begin
				wr_next.wr_data = {slots_q[ch][4:0], cur_q.channel};
			end
			fmcrw_pkg::CMD_KEY_OFF: begin
			end
			fmcrw_pkg::CMD_PAN: begin
				wr_next.reg_addr = fmcrw_pkg::ADDR_PAN + {5'b00000, cur_q.channel};
				wr_next.wr_data = {cur_q.arg[1:0], 6'b000000} | fb_conn_q[ch];
			end
			default: begin
				emits = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!wr_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (!emits) begin
						state_q <= ST_IDLE;
					end else if (load) begin
						if (wr_next.last) begin
							state_q <= ST_IDLE;
							step_q  <= '0;
						end else begin
							step_q <= step_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (load) begin
			out_q <= wr_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS*4; i++) begin
				op_level_q[i] <= '0;
			end
			for (int i = 0; i < CHANNELS; i++) begin
				fb_conn_q[i] <= '0;
				carrier_q[i] <= '0;
				slots_q[i]   <= '0;
			end
		end else if (state_q == ST_RUN) begin
			if (cur_q.cmd == fmcrw_pkg::CMD_OP_LEVEL) begin
				op_level_q[{ch, cur_q.op_index}] <= cur_q.arg;
			end else if (cur_q.cmd == fmcrw_pkg::CMD_CONNECT) begin
				fb_conn_q[ch] <= cur_q.arg;
				carrier_q[ch] <= fmcrw_pkg::CARRIER_TABLE[cur_q.arg[2:0]];
				slots_q[ch]   <= cur_q.key_slots;
			end
		end
	end

	assign wr_valid = out_valid_q;
	assign wr_item = out_q;

	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> step_q == 2'd0) else $error("step left set while idle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		load && wr_next.last |=> state_q == ST_IDLE) else $error("command runs past last write");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && wr_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled write not held");

endmodule

`default_nettype wire

/* hw/rtl/fm_channel_register_writer.sv */
// FM channel register writer.
// Command channel (cmd_valid / cmd_stall / cmd_item): one channel command per
// transaction. Set operator level and set connection only update the stored
// timbre state; volume yields four register writes, tone two, key on, key off
// and pan one each. Commands with an unused code or a channel at or above
// CHANNELS are taken and dropped.
// Write channel (wr_valid / wr_stall / wr_item): one address/data pair per
// transaction, last set on the final write of a command.
// Commands enter a queue of QUEUE_DEPTH entries; the executor takes one entry
// per command and emits one write per cycle into an output register unless
// wr_stall holds it. A command goes from the queue into the executor's
// command register, and its writes into the output register. The executor
// dequeues a command only when idle, then emits its writes in order, or makes
// the state update of a command without writes. The executor is the rate limit.
// cmd_stall rises only when the queue is full. While wr_stall is high the
// output register holds any write it has and the executor waits to emit its next.
// Reset clears all timbre state to zero, empties the queue and drops any
// pending write.
`default_nettype none

module fm_channel_register_writer #(
	parameter int CHANNELS    = 8,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	output logic                 cmd_stall,
	input  fmcrw_pkg::cmd_item_t cmd_item,
	output logic                 wr_valid,
	input  wire                  wr_stall,
	output fmcrw_pkg::wr_item_t  wr_item
);

	fmcrw_pkg::qstat_t qstat;
	fmcrw_pkg::entry_t push_entry;
	fmcrw_pkg::entry_t head;
	logic              push;
	logic              pop;

	fmcrw_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.cmd_valid(cmd_valid),
		.cmd_item (cmd_item),
		.qstat    (qstat),
		.cmd_stall(cmd_stall),
		.push     (push),
		.entry    (push_entry)
	);

	fmcrw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	fmcrw_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.wr_stall(wr_stall),
		.wr_valid(wr_valid),
		.wr_item (wr_item)
	);

endmodule

`default_nettype wire
